[hw/rtl/robot_remote_drive_controller_core_assert.svh]
// assertion macros used by the drive controller checker
`ifndef ROBOT_REMOTE_DRIVE_CONTROLLER_CORE_ASSERT_SVH
`define ROBOT_REMOTE_DRIVE_CONTROLLER_CORE_ASSERT_SVH

// checked on every rising edge outside reset
`define RRDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rrdc assertion failed");

// checked on every rising edge, reset included
`define RRDC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rrdc assertion failed");

`endif

[hw/rtl/rrdc_pkg.sv]
// types and constants of the remote drive controller
package rrdc_pkg;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [7:0] CMD_HEAD       = 8'd121;
  localparam logic [7:0] CMD_MANUAL_ON  = 8'd122;
  localparam logic [7:0] CMD_MANUAL_OFF = 8'd123;
  localparam logic [7:0] SET_HEAD       = 8'd111;
  localparam logic [7:0] ERR_REPLY      = 8'd100;
  localparam logic [7:0] GO_FORWARD     = 8'd8;
  localparam logic [7:0] GO_LEFT        = 8'd4;
  localparam logic [7:0] GO_RIGHT       = 8'd6;

  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned FCNT_W    = 3;
  localparam logic [FCNT_W-1:0] FRAME_LAST = FCNT_W'(FRAME_LEN - 1);

  localparam logic [6:0] TICKS_IDLE       = 7'd110;
  localparam logic [6:0] MANUAL_BLINK_END = 7'd100;
  localparam logic [7:0] AUTO_BLINK_END   = 8'd255;

  localparam logic [7:0] GAIN_RST   = 8'd2;
  localparam logic [7:0] THRESH_RST = 8'd20;
  localparam logic [7:0] SLOW_RST   = 8'd30;
  localparam logic [7:0] FAST_RST   = 8'd60;
  localparam logic [7:0] TURN_RST   = 8'd40;

  // what a received byte did to the frame
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply;
    logic       manual_on;
    logic       manual_off;
    logic       go_forward;
    logic       go_left;
    logic       go_right;
    logic       settings;
    logic [7:0] gain;
    logic [7:0] thresh;
    logic [7:0] slow;
    logic [7:0] fast;
    logic [7:0] turn;
  } frame_evt_t;

endpackage

[hw/rtl/robot_remote_drive_controller_core.sv]
// Remote drive controller for a line-following robot. Each transaction on the
// input channel is one event: a received serial byte (mode 0), a timer tick
// (mode 1) or a line sensor sample (mode 2); mode 3 changes nothing. Every
// event produces exactly one result transaction. The block takes one event
// per clock cycle while results are not stalled. An accepted event sits in
// the input register until the result register can load; all state updates
// happen at once as the result register loads, and the result is offered
// from that edge on. While a result is stalled, one more event can
// enter the input register before in_ready drops.
// SENSOR_COUNT sets the number of sensor channels in a sweep; DRIVE_TICKS
// sets how many manual ticks a forward, left or right drive lasts.
module robot_remote_drive_controller_core
  import rrdc_pkg::*;
#(
  parameter int unsigned SENSOR_COUNT = 6,
  parameter int unsigned DRIVE_TICKS  = 60
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reply_valid,
  output logic [7:0] reply_byte,
  output logic       motor_valid,
  output logic [7:0] right_speed,
  output logic [7:0] left_speed,
  output logic       led,
  output logic [5:0] sensor_mask,
  output logic       sensors_ready,
  output logic       manual,
  output logic [7:0] gain,
  output logic [7:0] slow_speed
);

  localparam int unsigned CH_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(SENSOR_COUNT - 1);
  localparam logic [6:0]      DRIVE_END = 7'(DRIVE_TICKS);

  // input register
  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [7:0] s1_value;
  logic       advance;

  // controller state
  logic                    manual_flag, manual_flag_next;
  logic                    led_level, led_level_next;
  logic [7:0]              auto_blink_count, auto_blink_count_next;
  logic [6:0]              manual_blink_count, manual_blink_count_next;
  logic [6:0]              forward_ticks, forward_ticks_next;
  logic [6:0]              left_ticks, left_ticks_next;
  logic [6:0]              right_ticks, right_ticks_next;
  logic [SENSOR_COUNT-1:0] line_mask, line_mask_next;
  logic [CH_W-1:0]         sensor_channel, sensor_channel_next;
  logic [7:0]              gain_reg, gain_reg_next;
  logic [7:0]              threshold_reg, threshold_reg_next;
  logic [7:0]              slow_reg, slow_reg_next;
  logic [7:0]              fast_reg, fast_reg_next;
  logic [7:0]              turn_reg, turn_reg_next;
  logic [7:0]              right_level, right_level_next;
  logic [7:0]              left_level, left_level_next;

  // result register
  logic       res_reply_valid, res_reply_valid_next;
  logic [7:0] res_reply, res_reply_next;
  logic       res_motor_valid, res_motor_valid_next;
  logic       res_ready, res_ready_next;

  logic [7:0] mask_pad;
  logic [CH_W-1:0] ch;

  frame_evt_t evt;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  rrdc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .byte_en (advance && s1_mode == MODE_BYTE),
    .byte_in (s1_value),
    .evt     (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= mode;
      s1_value <= value;
    end
  end

  always_comb begin
    manual_flag_next        = manual_flag;
    led_level_next          = led_level;
    auto_blink_count_next   = auto_blink_count;
    manual_blink_count_next = manual_blink_count;
    forward_ticks_next      = forward_ticks;
    left_ticks_next         = left_ticks;
    right_ticks_next        = right_ticks;
    line_mask_next          = line_mask;
    sensor_channel_next     = sensor_channel;
    gain_reg_next           = gain_reg;
    threshold_reg_next      = threshold_reg;
    slow_reg_next           = slow_reg;
    fast_reg_next           = fast_reg;
    turn_reg_next           = turn_reg;
    right_level_next        = right_level;
    left_level_next         = left_level;
    res_reply_valid_next    = 1'b0;
    res_reply_next          = '0;
    res_motor_valid_next    = 1'b0;
    res_ready_next          = 1'b0;
    ch = (sensor_channel > CH_LAST) ? '0 : sensor_channel;

    case (s1_mode)
      MODE_BYTE: begin
        res_reply_valid_next = evt.reply_valid;
        res_reply_next       = evt.reply;
        if (evt.manual_on || evt.manual_off) begin
          manual_flag_next     = evt.manual_on;
          right_level_next     = '0;
          left_level_next      = '0;
          res_motor_valid_next = 1'b1;
        end
        if (evt.go_forward) forward_ticks_next = '0;
        if (evt.go_left)    left_ticks_next    = '0;
        if (evt.go_right)   right_ticks_next   = '0;
        if (evt.settings) begin
          gain_reg_next      = evt.gain;
          threshold_reg_next = evt.thresh;
          slow_reg_next      = evt.slow;
          fast_reg_next      = evt.fast;
          turn_reg_next      = evt.turn;
        end
      end
      MODE_TICK: begin
        if (manual_flag) begin
          if (manual_blink_count == MANUAL_BLINK_END) begin
            manual_blink_count_next = '0;
            led_level_next          = !led_level;
          end else begin
            manual_blink_count_next = manual_blink_count + 7'd1;
          end
          res_motor_valid_next = 1'b1;
          // first active drive wins
          if (forward_ticks < DRIVE_END) begin
            forward_ticks_next = forward_ticks + 7'd1;
            right_level_next   = fast_reg;
            left_level_next    = fast_reg;
          end else if (left_ticks < DRIVE_END) begin
            left_ticks_next  = left_ticks + 7'd1;
            right_level_next = turn_reg;
            left_level_next  = '0;
          end else if (right_ticks < DRIVE_END) begin
            right_ticks_next = right_ticks + 7'd1;
            right_level_next = '0;
            left_level_next  = turn_reg;
          end else begin
            right_level_next = '0;
            left_level_next  = '0;
          end
        end else begin
          auto_blink_count_next = auto_blink_count + 8'd1;
          if (auto_blink_count == AUTO_BLINK_END) begin
            // steady on while some but not all sensors see the line
            if (line_mask != '0 && line_mask != '1) begin
              led_level_next = 1'b1;
            end else begin
              led_level_next = !led_level;
            end
          end
        end
      end
      MODE_SAMPLE: begin
        if (!manual_flag) begin
          line_mask_next[ch] = (s1_value > threshold_reg);
          if (ch == CH_LAST) begin
            sensor_channel_next = '0;
            res_ready_next      = 1'b1;
          end else begin
            sensor_channel_next = ch + CH_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_flag        <= 1'b0;
      led_level          <= 1'b0;
      auto_blink_count   <= '0;
      manual_blink_count <= '0;
      forward_ticks      <= TICKS_IDLE;
      left_ticks         <= TICKS_IDLE;
      right_ticks        <= TICKS_IDLE;
      line_mask          <= '0;
      sensor_channel     <= '0;
      gain_reg           <= GAIN_RST;
      threshold_reg      <= THRESH_RST;
      slow_reg           <= SLOW_RST;
      fast_reg           <= FAST_RST;
      turn_reg           <= TURN_RST;
      right_level        <= '0;
      left_level         <= '0;
    end else if (advance) begin
      manual_flag        <= manual_flag_next;
      led_level          <= led_level_next;
      auto_blink_count   <= auto_blink_count_next;
      manual_blink_count <= manual_blink_count_next;
      forward_ticks      <= forward_ticks_next;
      left_ticks         <= left_ticks_next;
      right_ticks        <= right_ticks_next;
      line_mask          <= line_mask_next;
      sensor_channel     <= sensor_channel_next;
      gain_reg           <= gain_reg_next;
      threshold_reg      <= threshold_reg_next;
      slow_reg           <= slow_reg_next;
      fast_reg           <= fast_reg_next;
      turn_reg           <= turn_reg_next;
      right_level        <= right_level_next;
      left_level         <= left_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reply_valid <= res_reply_valid_next;
      res_reply       <= res_reply_next;
      res_motor_valid <= res_motor_valid_next;
      res_ready       <= res_ready_next;
    end
  end

  // state only moves when the result register loads, so it matches the held result
  assign mask_pad      = 8'(line_mask);
  assign reply_valid   = res_reply_valid;
  assign reply_byte    = res_reply;
  assign motor_valid   = res_motor_valid;
  assign right_speed   = right_level;
  assign left_speed    = left_level;
  assign led           = led_level;
  assign sensor_mask   = mask_pad[5:0];
  assign sensors_ready = res_ready;
  assign manual        = manual_flag;
  assign gain          = gain_reg;
  assign slow_speed    = slow_reg;

endmodule

[hw/rtl/rrdc_frame.sv]
// serial frame assembly and command decode
module rrdc_frame
  import rrdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic [7:0] byte_in,
  output frame_evt_t evt
);

  logic [7:0]        frame_bytes [FRAME_LEN];
  logic [FCNT_W-1:0] frame_count;
  logic [FCNT_W-1:0] frame_count_next;
  logic [7:0]        head;
  logic [7:0]        second;

  always_comb begin
    head   = (frame_count == '0) ? byte_in : frame_bytes[0];
    second = (frame_count == FCNT_W'(1)) ? byte_in : frame_bytes[1];

    evt = '0;
    evt.gain   = frame_bytes[1];
    evt.thresh = frame_bytes[2];
    evt.slow   = frame_bytes[3];
    evt.fast   = frame_bytes[4];
    evt.turn   = byte_in;
    frame_count_next = frame_count + FCNT_W'(1);

    if (frame_count != '0 && head == CMD_HEAD) begin
      frame_count_next = '0;
      evt.reply_valid  = 1'b1;
      evt.reply        = CMD_HEAD;
      case (second)
        CMD_MANUAL_ON:  evt.manual_on  = 1'b1;
        CMD_MANUAL_OFF: evt.manual_off = 1'b1;
        GO_FORWARD:     evt.go_forward = 1'b1;
        GO_LEFT:        evt.go_left    = 1'b1;
        GO_RIGHT:       evt.go_right   = 1'b1;
        default:        ;
      endcase
    end else if (frame_count == FRAME_LAST) begin
      frame_count_next = '0;
      evt.reply_valid  = 1'b1;
      if (head == SET_HEAD) begin
        evt.reply    = SET_HEAD;
        evt.settings = 1'b1;
      end else begin
        evt.reply = ERR_REPLY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (byte_en) begin
      frame_count <= frame_count_next;
    end
  end

  // byte storage is written at the frame position and is not cleared between frames
  always_ff @(posedge clk) begin
    if (byte_en) begin
      frame_bytes[frame_count] <= byte_in;
    end
  end

endmodule

[hw/rtl/rrdc_checker.sv]
// port-level checks for the drive controller, bound to the top level
`include "robot_remote_drive_controller_core_assert.svh"

module rrdc_checker
  import rrdc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       reply_valid,
  input logic [7:0] reply_byte,
  input logic       motor_valid,
  input logic [7:0] right_speed,
  input logic [7:0] left_speed,
  input logic       sensors_ready,
  input logic       manual
);

  logic reply_known;

  assign reply_known = (reply_byte == CMD_HEAD) || (reply_byte == SET_HEAD) ||
                       (reply_byte == ERR_REPLY);

  // a reply is always one of the three known bytes
  `RRDC_ASSERT(a_reply_code, out_valid && reply_valid |-> reply_known)

  // no reply means a zero byte
  `RRDC_ASSERT(a_reply_idle, out_valid && !reply_valid |-> reply_byte == '0)

  // a sweep only completes in automatic mode
  `RRDC_ASSERT(a_sweep_auto, out_valid && sensors_ready |-> !manual)

  // a motor write in automatic mode is the stop from leaving manual mode
  `RRDC_ASSERT(a_auto_stop, out_valid && motor_valid && !manual |-> right_speed == '0 && left_speed == '0)

  // a stalled result transaction stays offered
  `RRDC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

endmodule

bind robot_remote_drive_controller_core rrdc_checker u_rrdc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the remote drive controller core with random flow control
module testbench;
  import rrdc_pkg::*;

  localparam int unsigned NUM_SENSORS = 6;
  localparam int unsigned DRIVE_LEN   = 60;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [5:0]  FULL_MASK   = 6'((1 << NUM_SENSORS) - 1);
  localparam int          ITEM_TARGET = 1250;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
  } drive_event_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       motor_valid;
    logic [7:0] right_speed;
    logic [7:0] left_speed;
    logic       led;
    logic [5:0] sensor_mask;
    logic       sensors_ready;
    logic       manual;
    logic [7:0] gain;
    logic [7:0] slow_speed;
  } drive_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] mode = MODE_BYTE;
  logic [7:0] value = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       motor_valid;
  logic [7:0] right_speed;
  logic [7:0] left_speed;
  logic       led;
  logic [5:0] sensor_mask;
  logic       sensors_ready;
  logic       manual;
  logic [7:0] gain;
  logic [7:0] slow_speed;

  robot_remote_drive_controller_core #(
    .SENSOR_COUNT(NUM_SENSORS),
    .DRIVE_TICKS (DRIVE_LEN)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_valid  (reply_valid),
    .reply_byte   (reply_byte),
    .motor_valid  (motor_valid),
    .right_speed  (right_speed),
    .left_speed   (left_speed),
    .led          (led),
    .sensor_mask  (sensor_mask),
    .sensors_ready(sensors_ready),
    .manual       (manual),
    .gain         (gain),
    .slow_speed   (slow_speed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // controller state as the predictor sees it
  logic [7:0] frame_q [FRAME_LEN];
  logic [2:0] frame_cnt;
  logic       manual_mode;
  logic       led_on;
  logic [7:0] auto_blink;
  logic [6:0] manual_blink;
  logic [6:0] fwd_ticks, lft_ticks, rgt_ticks;
  logic [5:0] line_bits;
  logic [2:0] channel;
  logic [7:0] gain_set, thresh_set, slow_set, fast_set, turn_set;
  logic [7:0] right_lvl, left_lvl;

  drive_event_t  pending_events[$];
  drive_result_t expected_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;

  task automatic clear_controller_state();
    foreach (frame_q[i]) frame_q[i] = 8'd0;
    frame_cnt    = '0;
    manual_mode  = 1'b0;
    led_on       = 1'b0;
    auto_blink   = '0;
    manual_blink = '0;
    fwd_ticks    = TICKS_IDLE;
    lft_ticks    = TICKS_IDLE;
    rgt_ticks    = TICKS_IDLE;
    line_bits    = '0;
    channel      = '0;
    gain_set     = GAIN_RST;
    thresh_set   = THRESH_RST;
    slow_set     = SLOW_RST;
    fast_set     = FAST_RST;
    turn_set     = TURN_RST;
    right_lvl    = '0;
    left_lvl     = '0;
  endtask

  function automatic drive_result_t predict_event(logic [1:0] m, logic [7:0] v);
    drive_result_t r;
    int unsigned ch;
    r = '0;
    case (m)
      MODE_BYTE: begin
        if (frame_cnt > 3'(FRAME_LEN - 1)) frame_cnt = '0;
        frame_q[frame_cnt] = v;
        frame_cnt = frame_cnt + 3'd1;
        if (frame_cnt > 3'd1 && frame_q[0] == CMD_HEAD) begin
          frame_cnt = '0;
          r.reply_valid = 1'b1;
          r.reply_byte = CMD_HEAD;
          case (frame_q[1])
            CMD_MANUAL_ON: begin
              manual_mode = 1'b1;
              right_lvl = '0;
              left_lvl = '0;
              r.motor_valid = 1'b1;
            end
            CMD_MANUAL_OFF: begin
              manual_mode = 1'b0;
              right_lvl = '0;
              left_lvl = '0;
              r.motor_valid = 1'b1;
            end
            GO_FORWARD: fwd_ticks = '0;
            GO_LEFT:    lft_ticks = '0;
            GO_RIGHT:   rgt_ticks = '0;
            default: ;
          endcase
        end else if (frame_cnt > 3'(FRAME_LEN - 1)) begin
          frame_cnt = '0;
          r.reply_valid = 1'b1;
          if (frame_q[0] == SET_HEAD) begin
            r.reply_byte = SET_HEAD;
            gain_set   = frame_q[1];
            thresh_set = frame_q[2];
            slow_set   = frame_q[3];
            fast_set   = frame_q[4];
            turn_set   = frame_q[5];
          end else begin
            r.reply_byte = ERR_REPLY;
            foreach (frame_q[i]) frame_q[i] = 8'd0;
          end
        end
      end
      MODE_TICK: begin
        if (manual_mode) begin
          if (manual_blink == MANUAL_BLINK_END) begin
            manual_blink = '0;
            led_on = ~led_on;
          end else begin
            manual_blink = manual_blink + 7'd1;
          end
          r.motor_valid = 1'b1;
          // first unfinished drive wins: forward, then left, then right
          if (fwd_ticks < DRIVE_LEN) begin
            fwd_ticks = fwd_ticks + 7'd1;
            right_lvl = fast_set;
            left_lvl = fast_set;
          end else if (lft_ticks < DRIVE_LEN) begin
            lft_ticks = lft_ticks + 7'd1;
            right_lvl = turn_set;
            left_lvl = '0;
          end else if (rgt_ticks < DRIVE_LEN) begin
            rgt_ticks = rgt_ticks + 7'd1;
            right_lvl = '0;
            left_lvl = turn_set;
          end else begin
            right_lvl = '0;
            left_lvl = '0;
          end
        end else begin
          if (auto_blink == AUTO_BLINK_END) begin
            auto_blink = '0;
            if (line_bits != '0 && line_bits != FULL_MASK) led_on = 1'b1;
            else led_on = ~led_on;
          end else begin
            auto_blink = auto_blink + 8'd1;
          end
        end
      end
      MODE_SAMPLE: begin
        if (!manual_mode) begin
          ch = channel;
          if (ch >= NUM_SENSORS) ch = 0;
          line_bits[ch] = (v > thresh_set);
          line_bits = line_bits & FULL_MASK;
          ch++;
          if (ch > NUM_SENSORS - 1) begin
            ch = 0;
            r.sensors_ready = 1'b1;
          end
          channel = 3'(ch);
        end
      end
      default: ;
    endcase
    r.right_speed = right_lvl;
    r.left_speed  = left_lvl;
    r.led         = led_on;
    r.sensor_mask = line_bits;
    r.manual      = manual_mode;
    r.gain        = gain_set;
    r.slow_speed  = slow_set;
    return r;
  endfunction

  // stimulus bookkeeping: frame alignment and mode as they will be once the queue is sent
  int         gen_pos = 0;
  logic [7:0] gen_head = 8'd0;
  logic       gen_manual = 1'b0;
  int         useful_count = 0;

  task automatic queue_event(input logic [1:0] m, input logic [7:0] v);
    drive_event_t ev;
    ev.mode = m;
    ev.value = v;
    pending_events.push_back(ev);
    if (m != MODE_SPARE && !(m == MODE_SAMPLE && gen_manual)) useful_count++;
    if (m == MODE_BYTE) begin
      gen_pos++;
      if (gen_pos == 1) gen_head = v;
      if (gen_pos >= 2 && gen_head == CMD_HEAD) begin
        if (v == CMD_MANUAL_ON) gen_manual = 1'b1;
        else if (v == CMD_MANUAL_OFF) gen_manual = 1'b0;
        gen_pos = 0;
      end else if (gen_pos >= FRAME_LEN) begin
        gen_pos = 0;
      end
    end
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // finish a half-sent frame with filler bytes so the next frame starts clean
  task automatic realign_frame();
    while (gen_pos != 0) queue_event(MODE_BYTE, rand_byte());
  endtask

  task automatic queue_command(input logic [7:0] cmd);
    realign_frame();
    queue_event(MODE_BYTE, CMD_HEAD);
    queue_event(MODE_BYTE, cmd);
  endtask

  task automatic queue_random_episode();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(0, 99);
      if (n < 20) b = CMD_MANUAL_ON;
      else if (n < 40) b = CMD_MANUAL_OFF;
      else if (n < 55) b = GO_FORWARD;
      else if (n < 70) b = GO_LEFT;
      else if (n < 85) b = GO_RIGHT;
      else b = rand_byte();
      queue_command(b);
    end else if (pick < 32) begin
      realign_frame();
      queue_event(MODE_BYTE, SET_HEAD);
      queue_event(MODE_BYTE, rand_byte());
      queue_event(MODE_BYTE, ($urandom_range(0, 3) == 0) ? rand_byte()
                                                          : 8'($urandom_range(10, 240)));
      repeat (3) queue_event(MODE_BYTE, rand_byte());
    end else if (pick < 38) begin
      realign_frame();
      do b = rand_byte(); while (b == CMD_HEAD || b == SET_HEAD);
      queue_event(MODE_BYTE, b);
      repeat (FRAME_LEN - 1) queue_event(MODE_BYTE, rand_byte());
    end else if (pick < 58) begin
      repeat ($urandom_range(1, 25)) queue_event(MODE_TICK, rand_byte());
    end else if (pick < 60) begin
      // long runs of ticks that can wrap the blink counters
      repeat ($urandom_range(100, 280)) queue_event(MODE_TICK, rand_byte());
    end else if (pick < 80) begin
      n = $urandom_range(0, 9);
      repeat (NUM_SENSORS) begin
        if (n < 6) b = rand_byte();
        else if (n < 8) b = 8'hFF;
        else b = 8'h00;
        queue_event(MODE_SAMPLE, b);
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(1, NUM_SENSORS - 1)) queue_event(MODE_SAMPLE, rand_byte());
    end else begin
      repeat ($urandom_range(1, 4)) queue_event(2'($urandom_range(0, 3)), rand_byte());
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input side: driver
  logic         in_taken = 1'b0;
  int           send_gap = 0;
  int           send_calm = 0;
  drive_event_t next_event;

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        next_event = pending_events.pop_front();
        in_valid <= 1'b1;
        mode <= next_event.mode;
        value <= next_event.value;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: back-pressure
  int stall_left = 0;
  int recv_calm = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: results are checked before the event of this edge is predicted
  drive_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no event waiting for it");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("reply_valid", want.reply_valid, reply_valid);
          check_field("reply_byte", want.reply_byte, reply_byte);
          check_field("motor_valid", want.motor_valid, motor_valid);
          check_field("right_speed", want.right_speed, right_speed);
          check_field("left_speed", want.left_speed, left_speed);
          check_field("led", want.led, led);
          check_field("sensor_mask", want.sensor_mask, sensor_mask);
          check_field("sensors_ready", want.sensors_ready, sensors_ready);
          check_field("manual", want.manual, manual);
          check_field("gain", want.gain, gain);
          check_field("slow_speed", want.slow_speed, slow_speed);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) expected_results.push_back(predict_event(mode, value));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    clear_controller_state();

    // directed: sensor extremes and threshold edges, one full sweep
    queue_event(MODE_SAMPLE, 8'd0);
    queue_event(MODE_SAMPLE, 8'd255);
    queue_event(MODE_SAMPLE, THRESH_RST);
    queue_event(MODE_SAMPLE, THRESH_RST + 8'd1);
    queue_event(MODE_SAMPLE, 8'd128);
    queue_event(MODE_SAMPLE, 8'd1);
    queue_event(MODE_TICK, 8'hFF);
    queue_event(MODE_SPARE, 8'hAA);
    queue_command(8'd77);                 // unknown command, ack only
    queue_command(GO_FORWARD);
    queue_command(CMD_MANUAL_ON);
    queue_event(MODE_SAMPLE, 8'h55);      // ignored while manual
    queue_event(MODE_TICK, 8'h00);
    queue_command(CMD_MANUAL_OFF);
    queue_event(MODE_BYTE, SET_HEAD);
    queue_event(MODE_BYTE, 8'd255);
    queue_event(MODE_BYTE, 8'd0);
    queue_event(MODE_BYTE, 8'd255);
    queue_event(MODE_BYTE, 8'd0);
    queue_event(MODE_BYTE, 8'd255);
    queue_event(MODE_BYTE, 8'd0);         // bad header, error reply
    queue_event(MODE_BYTE, 8'h7F);
    queue_event(MODE_BYTE, 8'h80);
    queue_event(MODE_BYTE, 8'hFE);
    queue_event(MODE_BYTE, 8'hFF);
    queue_event(MODE_BYTE, 8'h01);

    while (useful_count < ITEM_TARGET) queue_random_episode();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_events.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
